// ===== rtl/periodic_event_timer_bank_defines.svh =====
// ----------------------------------------------------------------------------
// periodic_event_timer_bank_defines
// Assertion macros shared by the timer bank RTL.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_EVENT_TIMER_BANK_DEFINES_SVH
`define PERIODIC_EVENT_TIMER_BANK_DEFINES_SVH

// Same-cycle implication, checked on aclk, off while in reset
`define PETB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on aclk, off while in reset
`define PETB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/petb_pkg.sv =====
// ----------------------------------------------------------------------------
// petb_pkg
// Types and constants of the periodic event timer bank.
// ----------------------------------------------------------------------------
package petb_pkg;

    // Bank size and derived widths
    localparam int NUM_TIMERS = 8;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
    localparam int CMP_W      = 8;

    // Field widths
    localparam int OP_W     = 3;
    localparam int ID_W     = 3;
    localparam int PERIOD_W = 16;
    localparam int TIME_W   = 29;
    localparam int TICK_W   = 32;

    // Fixed values
    localparam logic [PERIOD_W-1:0] RESET_PERIOD = 16'd1024;
    localparam logic [PERIOD_W-1:0] TIME_DIVISOR = 16'd10;

    // Divide by ten: multiply by ceil(2^35 / 10) in two 32x16 partial products
    localparam int               DIV_STEPS   = 2;
    localparam int               DIV_CNT_W   = $clog2(DIV_STEPS);
    localparam int               RECIP_W     = 16;
    localparam logic [RECIP_W-1:0] RECIP_LO  = 16'hCCCD;
    localparam logic [RECIP_W-1:0] RECIP_HI  = 16'hCCCC;
    localparam int               RECIP_SHIFT = 35;

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 3'd0,
        OP_SET_PERIOD = 3'd1,
        OP_READ_FLAG  = 3'd2,
        OP_CLEAR_FLAG = 3'd3,
        OP_READ_TIME  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_DIV,
        ST_RESP
    } state_t;

endpackage

// ===== rtl/periodic_event_timer_bank.sv =====
// ----------------------------------------------------------------------------
// periodic_event_timer_bank
// Bank of periodic event timers with a tick counter advanced by each tick command.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one command item (operation, timer_id, period);
//   the m_ channel returns exactly one result item (flag_value, time_ms)
//   per command, in order. Both channels use valid/ready.
//   How each command is carried out before its result reaches m_valid:
//     tick                  one timer per cycle through the shared subtract
//                           unit, memory read pipelined one entry ahead
//     read time             divide by ten as a multiply by the reciprocal,
//                           two 32x16 partial products
//     set, read, clear, other   applied on acceptance, then straight to the result step
//   One command is in work at a time; s_ready is high only while idle, so
//   a new command is taken only after the previous result has been loaded
//   into the output register.
//   A finished result sits in the output register, so the next command is
//   taken while the receiver stalls; that command then holds in its last
//   step until the output register is free.
//   Reset: all countdowns and periods read as 1024 (per-entry valid bits),
//   all flags clear, tick count zero. No clearing pass is needed.
// ----------------------------------------------------------------------------
`include "periodic_event_timer_bank_defines.svh"

module periodic_event_timer_bank
    import petb_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [OP_W-1:0]     s_operation,
    input  logic [ID_W-1:0]     s_timer_id,
    input  logic [PERIOD_W-1:0] s_period,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_flag_value,
    output logic [TIME_W-1:0]   m_time_ms
);

    // State
    state_t                state_reg, state_next;
    logic [OP_W-1:0]       op_reg, op_next;
    logic                  res_flag_reg, res_flag_next;
    logic [CNT_W-1:0]      rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]      wr_idx_reg, wr_idx_next;
    logic                  pend_reg, pend_next;
    logic [PERIOD_W-1:0]   rd_cd_reg, rd_rp_reg;
    logic                  rd_valid_reg;
    logic [TICK_W-1:0]     q_reg, q_next;
    logic [TICK_W+RECIP_W-1:0] prod_reg, prod_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic [TICK_W-1:0]     tick_count_reg, tick_count_next;
    logic [NUM_TIMERS-1:0] event_flag_reg, event_flag_next;
    logic [NUM_TIMERS-1:0] entry_valid_reg, entry_valid_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  m_flag_value_reg, m_flag_value_next;
    logic [TIME_W-1:0]     m_time_ms_reg, m_time_ms_next;

    // Countdown and period memories
    logic [PERIOD_W-1:0]   cd_mem [NUM_TIMERS];
    logic [PERIOD_W-1:0]   rp_mem [NUM_TIMERS];
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [IDX_W-1:0]      mem_raddr;
    logic [PERIOD_W-1:0]   mem_wcd, mem_wrp;

    // Shared subtract unit
    logic [PERIOD_W-1:0]   alu_a, alu_b;
    logic [PERIOD_W:0]     alu_diff;
    logic                  alu_borrow;

    // Reciprocal multiply for the divide by ten
    logic [RECIP_W-1:0]          mul_k;
    logic [TICK_W+RECIP_W-1:0]   mul_prod;
    logic [TICK_W+2*RECIP_W-1:0] mac_sum;

    // Misc
    logic                  s_accept;
    logic                  id_ok;
    logic [IDX_W-1:0]      id_idx;
    logic                  rd_active;
    logic                  out_free;
    logic                  div_last;
    logic [PERIOD_W-1:0]   eff_cd, eff_rp;

    assign s_ready      = (state_reg == ST_IDLE);
    assign s_accept     = s_valid && s_ready;
    assign id_ok        = (CMP_W'(s_timer_id) < CMP_W'(NUM_TIMERS));
    assign id_idx       = IDX_W'(s_timer_id);
    assign rd_active    = (rd_idx_reg < CNT_W'(NUM_TIMERS));
    assign out_free     = !m_valid_reg || m_ready;
    assign div_last     = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign mem_raddr    = rd_idx_reg[IDX_W-1:0];

    // Entries never written read as the reset period
    assign eff_cd       = rd_valid_reg ? rd_cd_reg : RESET_PERIOD;
    assign eff_rp       = rd_valid_reg ? rd_rp_reg : RESET_PERIOD;

    assign alu_diff     = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_borrow   = alu_diff[PERIOD_W];

    // Low half of the reciprocal first, then the high half shifted and added
    assign mul_k        = div_last ? RECIP_HI : RECIP_LO;
    assign mul_prod     = {{RECIP_W{1'b0}}, q_reg} * {{TICK_W{1'b0}}, mul_k};
    assign mac_sum      = {{RECIP_W{1'b0}}, prod_reg} + {mul_prod, {RECIP_W{1'b0}}};

    assign m_valid      = m_valid_reg;
    assign m_flag_value = m_flag_value_reg;
    assign m_time_ms    = m_time_ms_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (s_operation)
                        OP_TICK:      state_next = ST_TICK;
                        OP_READ_TIME: state_next = ST_DIV;
                        default:      state_next = ST_RESP;
                    endcase
                end
            end
            ST_TICK: begin
                if (!rd_active && !pend_reg) begin
                    state_next = ST_RESP;
                end
            end
            ST_DIV: begin
                if (div_last) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath control and register next values
    always_comb begin
        op_next           = op_reg;
        res_flag_next     = res_flag_reg;
        rd_idx_next       = rd_idx_reg;
        wr_idx_next       = wr_idx_reg;
        pend_next         = pend_reg;
        q_next            = q_reg;
        prod_next         = prod_reg;
        div_cnt_next      = div_cnt_reg;
        tick_count_next   = tick_count_reg;
        event_flag_next   = event_flag_reg;
        entry_valid_next  = entry_valid_reg;
        m_flag_value_next = m_flag_value_reg;
        m_time_ms_next    = m_time_ms_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        mem_we            = 1'b0;
        mem_waddr         = wr_idx_reg;
        mem_wcd           = eff_cd;
        mem_wrp           = eff_rp;
        alu_a             = eff_cd;
        alu_b             = 16'd1;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    op_next       = s_operation;
                    res_flag_next = 1'b0;
                    case (s_operation)
                        OP_TICK: begin
                            tick_count_next = tick_count_reg + 1'b1;
                            rd_idx_next     = '0;
                            pend_next       = 1'b0;
                        end
                        OP_SET_PERIOD: begin
                            if (id_ok) begin
                                mem_we                   = 1'b1;
                                mem_waddr                = id_idx;
                                mem_wcd                  = s_period;
                                mem_wrp                  = s_period;
                                entry_valid_next[id_idx] = 1'b1;
                                event_flag_next[id_idx]  = 1'b0;
                            end
                        end
                        OP_READ_FLAG: begin
                            res_flag_next = id_ok && event_flag_reg[id_idx];
                        end
                        OP_CLEAR_FLAG: begin
                            if (id_ok) begin
                                event_flag_next[id_idx] = 1'b0;
                            end
                        end
                        OP_READ_TIME: begin
                            q_next       = tick_count_reg;
                            div_cnt_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_TICK: begin
                // Issue the read of the next timer
                if (rd_active) begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                    wr_idx_next = rd_idx_reg[IDX_W-1:0];
                    pend_next   = 1'b1;
                end else begin
                    pend_next   = 1'b0;
                end
                // Decrement or reload the timer read last cycle
                if (pend_reg) begin
                    mem_we                       = 1'b1;
                    entry_valid_next[wr_idx_reg] = 1'b1;
                    if (alu_borrow) begin
                        mem_wcd                     = eff_rp;
                        event_flag_next[wr_idx_reg] = 1'b1;
                    end else begin
                        mem_wcd = alu_diff[PERIOD_W-1:0];
                    end
                end
            end
            ST_DIV: begin
                // Hold the low partial product, then add the high one and shift
                if (div_last) begin
                    q_next = TICK_W'(mac_sum[TICK_W+2*RECIP_W-1:RECIP_SHIFT]);
                end else begin
                    prod_next = mul_prod;
                end
                div_cnt_next = div_cnt_reg + 1'b1;
            end
            ST_RESP: begin
                // Load the result once the output register is free
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_flag_value_next = res_flag_reg;
                    m_time_ms_next    = (op_reg == OP_READ_TIME) ? q_reg[TIME_W-1:0] : '0;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            rd_idx_reg      <= '0;
            pend_reg        <= 1'b0;
            tick_count_reg  <= '0;
            event_flag_reg  <= '0;
            entry_valid_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            rd_idx_reg      <= rd_idx_next;
            pend_reg        <= pend_next;
            tick_count_reg  <= tick_count_next;
            event_flag_reg  <= event_flag_next;
            entry_valid_reg <= entry_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg           <= op_next;
        res_flag_reg     <= res_flag_next;
        wr_idx_reg       <= wr_idx_next;
        q_reg            <= q_next;
        prod_reg         <= prod_next;
        div_cnt_reg      <= div_cnt_next;
        m_flag_value_reg <= m_flag_value_next;
        m_time_ms_reg    <= m_time_ms_next;
    end

    // Memory write and registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cd_mem[mem_waddr] <= mem_wcd;
            rp_mem[mem_waddr] <= mem_wrp;
        end
        rd_cd_reg    <= cd_mem[mem_raddr];
        rd_rp_reg    <= rp_mem[mem_raddr];
        rd_valid_reg <= entry_valid_reg[mem_raddr];
    end

    // Checks
    `PETB_ASSERT_IMP(a_sweep_done, (state_reg == ST_TICK) && (state_next == ST_RESP), (rd_idx_reg == CNT_W'(NUM_TIMERS)) && !pend_reg, "tick sweep ended early")
    `PETB_ASSERT_IMP(a_quot_range, (state_reg == ST_RESP) && (op_reg == OP_READ_TIME), q_reg[TICK_W-1:TIME_W] == '0, "time quotient out of range")
    `PETB_ASSERT_NXT(a_tick_inc, s_accept && (s_operation == OP_TICK), tick_count_reg == $past(tick_count_reg) + 32'd1, "tick count not advanced")
    `PETB_ASSERT_IMP(a_mem_we, mem_we, ((state_reg == ST_TICK) && pend_reg) || (s_accept && (s_operation == OP_SET_PERIOD)), "unexpected memory write")

endmodule

// ===== dv/periodic_event_timer_bank_test.sv =====
// ----------------------------------------------------------------------------
// periodic_event_timer_bank_test
// Self-checking bench for the periodic event timer bank.
// ----------------------------------------------------------------------------
// A queue of command items (directed first, then random) feeds a clocked
// driver on the s_ channel. Every accepted command is applied to a local
// model of the counters, periods, flags and tick total, and the reply it
// produces is queued. A clocked monitor on the m_ channel compares each
// reply field by field against the oldest queued one. Both sides idle at
// random in changing proportions, the receiver holds off once for a long
// stretch, and the sender now and then waits for all replies to drain.
// ----------------------------------------------------------------------------
module periodic_event_timer_bank_test;
    import petb_pkg::*;

    // Operation codes the block does not define
    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam int RANDOM_ITEMS  = 880;
    localparam int PHASE_LEN     = 300;
    localparam int HOLD_AT       = 200;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 48;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_LOGGED    = 40;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [ID_W-1:0]     id;
        logic [PERIOD_W-1:0] period;
        logic                drain;
    } command_t;

    typedef struct packed {
        logic              flag;
        logic [TIME_W-1:0] time_ms;
    } reply_t;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_operation = '0;
    logic [ID_W-1:0]     s_timer_id  = '0;
    logic [PERIOD_W-1:0] s_period    = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic                m_flag_value;
    logic [TIME_W-1:0]   m_time_ms;

    // Local copy of the timer bank
    logic [PERIOD_W-1:0] timer_count  [NUM_TIMERS];
    logic [PERIOD_W-1:0] timer_reload [NUM_TIMERS];
    logic                timer_flag   [NUM_TIMERS];
    logic [TICK_W-1:0]   tick_total;

    command_t pending_cmds[$];
    reply_t   expected_replies[$];
    command_t in_flight;
    reply_t   oldest_reply;

    int accepted_cnt  = 0;
    int replied_cnt   = 0;
    int mismatch_cnt  = 0;
    int cycle_cnt     = 0;
    int hold_left     = 0;
    int hold_armed    = 1;
    int stalled_input = 0;
    int flags_raised  = 0;
    int op_seen [8];

    periodic_event_timer_bank DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_timer_id   (s_timer_id),
        .s_period     (s_period),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_flag_value (m_flag_value),
        .m_time_ms    (m_time_ms)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Restore the bank to its after-reset contents
    function automatic void clear_bank();
        for (int t = 0; t < NUM_TIMERS; t++) begin
            timer_count[t]  = RESET_PERIOD;
            timer_reload[t] = RESET_PERIOD;
            timer_flag[t]   = 1'b0;
        end
        tick_total = '0;
    endfunction

    // Apply one command to the local bank and return the reply it yields
    function automatic reply_t apply_command(command_t c);
        reply_t r;
        r = '0;
        case (c.op)
            OP_TICK: begin
                for (int t = 0; t < NUM_TIMERS; t++) begin
                    if (timer_count[t] != '0) begin
                        timer_count[t] = timer_count[t] - 1'b1;
                    end else begin
                        timer_count[t] = timer_reload[t];
                        timer_flag[t]  = 1'b1;
                    end
                end
                tick_total = tick_total + 1'b1;
            end
            OP_SET_PERIOD: begin
                if (c.id < NUM_TIMERS) begin
                    timer_count[c.id]  = c.period;
                    timer_reload[c.id] = c.period;
                    timer_flag[c.id]   = 1'b0;
                end
            end
            OP_READ_FLAG: begin
                if (c.id < NUM_TIMERS) begin
                    r.flag = timer_flag[c.id];
                end
            end
            OP_CLEAR_FLAG: begin
                if (c.id < NUM_TIMERS) begin
                    timer_flag[c.id] = 1'b0;
                end
            end
            OP_READ_TIME: begin
                r.time_ms = TIME_W'(tick_total / TIME_DIVISOR);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic void queue_cmd(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                      logic [PERIOD_W-1:0] period, logic drain);
        command_t c;
        c.op     = op;
        c.id     = id;
        c.period = period;
        c.drain  = drain;
        pending_cmds.push_back(c);
    endfunction

    // Idle percentages change with the number of items taken
    function automatic int send_idle_pct();
        if (accepted_cnt < PHASE_LEN) return 30;
        if (accepted_cnt < 2 * PHASE_LEN) return 56;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (accepted_cnt < PHASE_LEN) return 56;
        if (accepted_cnt < 2 * PHASE_LEN) return 30;
        return 0;
    endfunction

    task automatic report(input string msg);
        if (mismatch_cnt < MAX_LOGGED) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
        mismatch_cnt++;
    endtask

    // Driver: predict on accept, then offer the next item or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            clear_bank();
        end else begin
            if (s_valid && !s_ready) begin
                stalled_input++;
            end
            if (s_valid && s_ready) begin
                expected_replies.push_back(apply_command(in_flight));
                op_seen[in_flight.op]++;
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!s_valid || s_ready) begin
                if (pending_cmds.size() != 0
                        && $urandom_range(0, 99) >= send_idle_pct()
                        && (!pending_cmds[0].drain
                            || (!s_valid && accepted_cnt == replied_cnt))) begin
                    in_flight = pending_cmds.pop_front();
                    s_valid     <= 1'b1;
                    s_operation <= in_flight.op;
                    s_timer_id  <= in_flight.id;
                    s_period    <= in_flight.period;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, armed once partway through the run
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left  <= 0;
            hold_armed <= 1;
        end else if (hold_armed != 0 && accepted_cnt >= HOLD_AT) begin
            hold_left  <= HOLD_CYCLES;
            hold_armed <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: compare each reply with the oldest expectation
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                replied_cnt <= replied_cnt + 1;
                if (expected_replies.size() == 0) begin
                    report("reply arrived with nothing outstanding");
                end else begin
                    oldest_reply = expected_replies.pop_front();
                    if (m_flag_value === 1'b1) begin
                        flags_raised++;
                    end
                    if (m_flag_value !== oldest_reply.flag) begin
                        report($sformatf("flag_value %0b, expected %0b",
                                         m_flag_value, oldest_reply.flag));
                    end
                    if (m_time_ms !== oldest_reply.time_ms) begin
                        report($sformatf("time_ms %0d, expected %0d",
                                         m_time_ms, oldest_reply.time_ms));
                    end
                end
            end
            m_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct());
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial begin
        logic [ID_W-1:0]     rid;
        logic [PERIOD_W-1:0] rper;
        int                  pick;
        int                  span;

        foreach (op_seen[i]) op_seen[i] = 0;

        // Directed: zero period, extreme periods, flags, spare codes
        queue_cmd(OP_READ_TIME,  3'd0, 16'h0000, 1'b0);
        queue_cmd(OP_READ_FLAG,  3'd0, 16'h0000, 1'b0);
        queue_cmd(OP_SET_PERIOD, 3'd0, 16'h0000, 1'b0);
        queue_cmd(OP_TICK,       3'd0, 16'h0000, 1'b0);
        queue_cmd(OP_READ_FLAG,  3'd0, 16'h0000, 1'b0);
        queue_cmd(OP_CLEAR_FLAG, 3'd0, 16'hFFFF, 1'b0);
        queue_cmd(OP_READ_FLAG,  3'd0, 16'h0000, 1'b0);
        queue_cmd(OP_SET_PERIOD, 3'd7, 16'hFFFF, 1'b0);
        queue_cmd(OP_SET_PERIOD, 3'd1, 16'h0001, 1'b0);
        queue_cmd(OP_SET_PERIOD, 3'd2, 16'h5555, 1'b0);
        queue_cmd(OP_SET_PERIOD, 3'd5, 16'hAAAA, 1'b0);
        queue_cmd(OP_TICK,       3'd7, 16'hFFFF, 1'b0);
        queue_cmd(OP_TICK,       3'd0, 16'h0000, 1'b0);
        queue_cmd(OP_TICK,       3'd3, 16'h1234, 1'b0);
        queue_cmd(OP_TICK,       3'd4, 16'h8000, 1'b0);
        queue_cmd(OP_READ_FLAG,  3'd1, 16'h0000, 1'b0);
        queue_cmd(OP_READ_FLAG,  3'd7, 16'h0000, 1'b0);
        queue_cmd(OP_SPARE_5,    3'd7, 16'hFFFF, 1'b0);
        queue_cmd(OP_SPARE_6,    3'd3, 16'h00FF, 1'b0);
        queue_cmd(OP_SPARE_7,    3'd6, 16'hFF00, 1'b0);
        queue_cmd(OP_READ_TIME,  3'd7, 16'hFFFF, 1'b0);
        queue_cmd(OP_CLEAR_FLAG, 3'd1, 16'h0000, 1'b0);
        queue_cmd(OP_READ_FLAG,  3'd1, 16'h0000, 1'b0);
        queue_cmd(OP_READ_FLAG,  3'd2, 16'h0000, 1'b1);

        // Random: mostly short periods so events fire often, ticks dominate
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            rid  = ID_W'($urandom_range(0, NUM_TIMERS - 1));
            rper = PERIOD_W'($urandom_range(0, 65535));
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                queue_cmd(OP_TICK, rid, rper, (k % 100) == 50);
            end else if (pick < 55) begin
                span = $urandom_range(0, 9);
                if (span < 7) begin
                    rper = PERIOD_W'($urandom_range(0, 6));
                end else if (span < 9) begin
                    rper = PERIOD_W'($urandom_range(7, 40));
                end
                queue_cmd(OP_SET_PERIOD, rid, rper, (k % 100) == 50);
            end else if (pick < 75) begin
                queue_cmd(OP_READ_FLAG, rid, rper, (k % 100) == 50);
            end else if (pick < 85) begin
                queue_cmd(OP_CLEAR_FLAG, rid, rper, (k % 100) == 50);
            end else if (pick < 95) begin
                queue_cmd(OP_READ_TIME, rid, rper, (k % 100) == 50);
            end else begin
                queue_cmd(OP_SPARE_5 + OP_W'($urandom_range(0, 2)), rid, rper,
                          (k % 100) == 50);
            end
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for the queue to empty and every reply to come back
        @(negedge aclk);
        while (pending_cmds.size() != 0 || s_valid || accepted_cnt != replied_cnt) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_replies.size() != 0) begin
            report($sformatf("%0d replies never arrived", expected_replies.size()));
        end

        $display("Covered %0d commands: %0d ticks, %0d sets, %0d flag reads (%0d raised)",
                 accepted_cnt, op_seen[OP_TICK], op_seen[OP_SET_PERIOD],
                 op_seen[OP_READ_FLAG], flags_raised);
        $display("  %0d clears, %0d time reads, %0d spare codes, %0d input stall cycles",
                 op_seen[OP_CLEAR_FLAG], op_seen[OP_READ_TIME],
                 op_seen[OP_SPARE_5] + op_seen[OP_SPARE_6] + op_seen[OP_SPARE_7],
                 stalled_input);
        if (mismatch_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
